FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
    label: assert property (@(posedge clk) disable iff (rst) (expr)) \
        else $error("assertion failed");

// Check that a consequent follows from an antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/plil_pkg.sv
// Package with mode codes, register indexes and item kinds of the limiter.
`timescale 1ns / 1ps
package plil_pkg;

    typedef enum logic [2:0] {
        MODE_LINE   = 3'd0,
        MODE_VALUE  = 3'd1,
        MODE_PCT    = 3'd2,
        MODE_THREE  = 3'd3,
        MODE_MINMAX = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE  = 3'd0,
        CFG_BP_X0 = 3'd1,
        CFG_BP_X1 = 3'd2,
        CFG_BP_X2 = 3'd3,
        CFG_BP_Y0 = 3'd4,
        CFG_BP_Y1 = 3'd5,
        CFG_BP_Y2 = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_SEG    = 2'd1,
        KIND_PCT    = 2'd2
    } t_kind;

endpackage

FILE: sv/plil_div_cell.sv
// One restoring-division cell: produces one quotient bit per item and passes it on.
`timescale 1ns / 1ps
module plil_div_cell import plil_pkg::*; #(
    parameter int DW = 33,
    parameter int SW = 66
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_low,
    input  logic [DW-1:0] i_quo,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_low,
    output logic [DW-1:0] o_quo,
    output logic [DW-1:0] o_div,
    output logic [SW-1:0] o_side
);
    logic          r_valid;
    logic [DW-1:0] r_rem, r_low, r_quo, r_div;
    logic [SW-1:0] r_side;
    logic [DW:0]   trial, diff;
    logic          ge;
    logic [DW-1:0] n_rem;

    always_comb begin
        trial = {i_rem, i_low[DW-1]};
        diff  = trial - {1'b0, i_div};
        ge    = trial >= {1'b0, i_div};
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem  <= n_rem;
        r_low  <= {i_low[DW-2:0], 1'b0};
        r_quo  <= {i_quo[DW-2:0], ge};
        r_div  <= i_div;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_side  = r_side;
endmodule

FILE: sv/piecewise_linear_limiter_core.sv
// Top level of the piecewise-linear limiter: decode, multiply, division chain, output.
`timescale 1ns / 1ps
// Usage:
//   Configure with i_cfg_we/i_cfg_idx/i_cfg_data while no item is in flight:
//   index 0 mode, 1..3 bp_x0..bp_x2, 4..6 bp_y0..bp_y2; index 7 is ignored.
//   Issue an item by raising start with i_sample_in; busy is always low, so
//   an item is taken at every edge where start is high.
//   The result shows on o_limited_out with o_valid high for one cycle,
//   once the item has passed through every stage listed below.
//   Throughput is one item per cycle: a decode stage, a multiply stage, a
//   chain of DATA_WIDTH + 1 division cells (one quotient bit each) and an
//   output register all advance every cycle.
//   Reset clears all valid bits in the pipeline and loads the default
//   breakpoints (mode minmax over the full range, so samples pass through).
//   The receiver cannot stall: each result is presented exactly once.
module piecewise_linear_limiter_core import plil_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_sample_in,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_limited_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);
    localparam int W  = DATA_WIDTH;
    localparam int XW = DATA_WIDTH + 1;
    localparam int PW = 2 * XW;
    localparam int SW = 2 * W + 2;
    localparam int MW = PW - FRAC_BITS;

    // configuration registers
    t_mode               r_mode;
    logic signed [W-1:0] r_bp_x0, r_bp_x1, r_bp_x2, r_bp_y0, r_bp_y1, r_bp_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MINMAX;
            r_bp_x0 <= '0;
            r_bp_x1 <= {1'b1, {(W-1){1'b0}}};
            r_bp_x2 <= {1'b0, {(W-1){1'b1}}};
            r_bp_y0 <= '0;
            r_bp_y1 <= '0;
            r_bp_y2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[2:0]);
                CFG_BP_X0: r_bp_x0 <= i_cfg_data;
                CFG_BP_X1: r_bp_x1 <= i_cfg_data;
                CFG_BP_X2: r_bp_x2 <= i_cfg_data;
                CFG_BP_Y0: r_bp_y0 <= i_cfg_data;
                CFG_BP_Y1: r_bp_y1 <= i_cfg_data;
                CFG_BP_Y2: r_bp_y2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    // decode stage: pick the rule and the segment, resolve trivial fractions
    logic signed [XW-1:0] x_e, x0_e, x1_e, x2_e, xc, off, dx, dy;
    logic signed [W-1:0]  ya, yb, dir;
    logic                 use_seg;
    logic [XW-1:0]        m_off, m_dx, m_dy, n_a, n_b, n_d;
    t_kind                n_kind;
    logic                 n_neg;
    logic signed [W-1:0]  n_ya, n_dir;

    always_comb begin
        x_e  = {i_sample_in[W-1], i_sample_in};
        x0_e = {r_bp_x0[W-1], r_bp_x0};
        x1_e = {r_bp_x1[W-1], r_bp_x1};
        x2_e = {r_bp_x2[W-1], r_bp_x2};
        xc      = x_e;
        off     = '0;
        dx      = '0;
        ya      = r_bp_y1;
        yb      = r_bp_y2;
        use_seg = 1'b0;
        dir     = i_sample_in;
        n_kind  = KIND_DIRECT;
        n_neg   = 1'b0;
        n_a     = '0;
        n_b     = '0;
        case (r_mode)
            MODE_LINE: begin
                if (r_bp_x1 == r_bp_x2) begin
                    dir = r_bp_y1;
                end else begin
                    // clamp x into the span of x1 and x2
                    if (x1_e < x2_e) begin
                        xc = (x_e < x1_e) ? x1_e : ((x_e > x2_e) ? x2_e : x_e);
                    end else begin
                        xc = (x_e < x2_e) ? x2_e : ((x_e > x1_e) ? x1_e : x_e);
                    end
                    off     = xc - x1_e;
                    dx      = x2_e - x1_e;
                    use_seg = 1'b1;
                end
            end
            MODE_VALUE: begin
                dir = r_bp_x1;
            end
            MODE_PCT: begin
                n_kind = KIND_PCT;
                n_neg  = i_sample_in[W-1] ^ r_bp_x1[W-1];
                n_a    = x_e[XW-1] ? -x_e : x_e;
                n_b    = x1_e[XW-1] ? -x1_e : x1_e;
            end
            MODE_THREE: begin
                if (x_e <= x1_e) begin
                    if (r_bp_x1 == r_bp_x0) begin
                        dir = r_bp_y1;
                    end else begin
                        off     = x_e - x0_e;
                        dx      = x1_e - x0_e;
                        ya      = r_bp_y0;
                        yb      = r_bp_y1;
                        use_seg = 1'b1;
                    end
                end else begin
                    if (r_bp_x2 == r_bp_x1) begin
                        dir = r_bp_y1;
                    end else begin
                        off     = x_e - x1_e;
                        dx      = x2_e - x1_e;
                        use_seg = 1'b1;
                    end
                end
            end
            MODE_MINMAX: begin
                dir = ($signed(i_sample_in) < r_bp_x2) ? $signed(i_sample_in) : r_bp_x2;
                dir = (dir > r_bp_x1) ? dir : r_bp_x1;
            end
            default: begin
                dir = i_sample_in;
            end
        endcase
        dy    = {yb[W-1], yb} - {ya[W-1], ya};
        m_off = off[XW-1] ? -off : off;
        m_dx  = dx[XW-1] ? -dx : dx;
        m_dy  = dy[XW-1] ? -dy : dy;
        n_d   = m_dx;
        if (use_seg) begin
            // fraction at or below zero holds ya, at or above one holds yb
            if (off == '0 || (off[XW-1] != dx[XW-1])) begin
                dir = ya;
            end else if (m_off >= m_dx) begin
                dir = yb;
            end else begin
                n_kind = KIND_SEG;
                n_neg  = dy[XW-1];
                n_a    = m_off;
                n_b    = m_dy;
            end
        end
        n_ya  = ya;
        n_dir = dir;
    end

    logic                r_s0_valid;
    t_kind               r_s0_kind;
    logic                r_s0_neg;
    logic [XW-1:0]       r_s0_a, r_s0_b, r_s0_d;
    logic signed [W-1:0] r_s0_ya, r_s0_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
        r_s0_kind <= n_kind;
        r_s0_neg  <= n_neg;
        r_s0_a    <= n_a;
        r_s0_b    <= n_b;
        r_s0_d    <= n_d;
        r_s0_ya   <= n_ya;
        r_s0_dir  <= n_dir;
    end

    // multiply stage, shared by percent and segment items
    logic                r_s1_valid;
    t_kind               r_s1_kind;
    logic                r_s1_neg;
    logic [PW-1:0]       r_s1_prod;
    logic [XW-1:0]       r_s1_d;
    logic signed [W-1:0] r_s1_ya, r_s1_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
        r_s1_kind <= r_s0_kind;
        r_s1_neg  <= r_s0_neg;
        r_s1_prod <= r_s0_a * r_s0_b;
        r_s1_d    <= r_s0_d;
        r_s1_ya   <= r_s0_ya;
        r_s1_dir  <= r_s0_dir;
    end

    // percent finish: drop fraction bits and saturate
    logic [MW-1:0]   pct_m;
    logic [W-1:0]    pct_val, side_dir;
    logic [SW-1:0]   side_in;

    always_comb begin
        pct_m = r_s1_prod[PW-1:FRAC_BITS];
        if (r_s1_neg) begin
            if (pct_m > MW'({1'b1, {(W-1){1'b0}}})) begin
                pct_val = {1'b1, {(W-1){1'b0}}};
            end else begin
                pct_val = -pct_m[W-1:0];
            end
        end else begin
            if (pct_m > MW'({1'b0, {(W-1){1'b1}}})) begin
                pct_val = {1'b0, {(W-1){1'b1}}};
            end else begin
                pct_val = pct_m[W-1:0];
            end
        end
        side_dir = (r_s1_kind == KIND_PCT) ? pct_val : r_s1_dir;
        side_in  = {(r_s1_kind == KIND_SEG), r_s1_neg, r_s1_ya, side_dir};
    end

    // division chain: one quotient bit per cell
    logic          c_valid [XW+1];
    logic [XW-1:0] c_rem   [XW+1];
    logic [XW-1:0] c_low   [XW+1];
    logic [XW-1:0] c_quo   [XW+1];
    logic [XW-1:0] c_div   [XW+1];
    logic [SW-1:0] c_side  [XW+1];

    assign c_valid[0] = r_s1_valid;
    assign c_rem[0]   = r_s1_prod[PW-1:XW];
    assign c_low[0]   = r_s1_prod[XW-1:0];
    assign c_quo[0]   = '0;
    assign c_div[0]   = r_s1_d;
    assign c_side[0]  = side_in;

    for (genvar g = 0; g < XW; g++) begin : g_cell
        plil_div_cell #(.DW(XW), .SW(SW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]),
            .i_rem  (c_rem[g]),
            .i_low  (c_low[g]),
            .i_quo  (c_quo[g]),
            .i_div  (c_div[g]),
            .i_side (c_side[g]),
            .o_valid(c_valid[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_low  (c_low[g+1]),
            .o_quo  (c_quo[g+1]),
            .o_div  (c_div[g+1]),
            .o_side (c_side[g+1])
        );
    end

    // output stage: apply the quotient to ya in the direction of yb, or pass the direct or percent value
    logic          e_seg, e_neg;
    logic [W-1:0]  e_ya, e_dir, e_q, n_out;
    logic          r_valid;
    logic [W-1:0]  r_out;

    always_comb begin
        e_seg = c_side[XW][SW-1];
        e_neg = c_side[XW][SW-2];
        e_ya  = c_side[XW][2*W-1:W];
        e_dir = c_side[XW][W-1:0];
        e_q   = c_quo[XW][W-1:0];
        if (e_seg) begin
            n_out = e_neg ? (e_ya - e_q) : (e_ya + e_q);
        end else begin
            n_out = e_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c_valid[XW];
        end
        r_out <= n_out;
    end

    assign o_valid       = r_valid;
    assign o_limited_out = r_out;
endmodule

FILE: sv/plil_checker.sv
// Port-level checker for the limiter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plil_checker import plil_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    localparam int LAT = DATA_WIDTH + 4;

    `ASSERT_ALWAYS(a_never_busy, i_clk, !i_rst_n, !busy)
    `ASSERT_IMPL(a_result_has_item, i_clk, !i_rst_n, o_valid, $past(start, LAT))
    `ASSERT_IMPL(a_item_gives_result, i_clk, !i_rst_n, start, ##LAT o_valid)
endmodule

bind piecewise_linear_limiter_core plil_checker #(.DATA_WIDTH(DATA_WIDTH)) u_plil_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid)
);
